### hdl/nnds_pkg.sv
// ----------------------------------------------------------------------------
// nnds_pkg
// Shared types and constants of the nearest-neighbor frame downscaler:
// field widths, register indexes and reset values, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nnds_pkg;

   // Widths fixed by the stream and register formats.
   localparam int PIX_W     = 32;
   localparam int CFG_W     = 14;
   localparam int CSR_IDX_W = 3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 3'd4;

   // Register reset values.
   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 14'd1920;
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 14'd1080;
   localparam logic [CFG_W-1:0] RST_LINE_PITCH = 14'd1920;
   localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 14'd1920;
   localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 14'd1080;

   // Controller states.
   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,   // streaming pixels
      ST_DIVC = 4'b0010,   // dividing for the column step
      ST_DIVR = 4'b0100,   // dividing for the row step
      ST_PEND = 4'b1000    // frame-start pixel waits to be processed
   } nnds_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step_live;   // process the pixel on the request channel
      logic step_held;   // process the held frame-start pixel
      logic capture;     // hold a frame-start pixel and clear the counters
      logic div_col;     // start the column step division
      logic div_row;     // start the row step division
      logic load_col;    // store the column step result
      logic load_row;    // store the row step result
   } nnds_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // the result register can take a result this cycle
      logic frame_wrap;  // the next pixel processed closes the source frame
      logic div_done;    // the divider has a result
   } nnds_status_type;

endpackage

### hdl/nearest_neighbor_frame_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_downscaler
// Nearest-neighbor downscaler for a raster stream of 32-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries the source frame in raster order, line_pitch
// pixels per line, with tuser marking the first pixel of a frame. The
// response channel carries the selected pixels; tlast marks the end of an
// output row and tuser the end of the output frame. Sizes are written on
// the csr port between frames, while no pixel is in flight.
// Ordinary pixels are taken one per cycle while responses are taken; a
// selected pixel shows on the response channel the cycle after it is taken.
// A frame-start pixel, or the source frame closing without one, runs the
// serial divider twice (column step, then row step, one quotient bit a
// cycle). After an unmarked frame close the request channel pauses until
// both divisions are done. A frame-start pixel is held and processed after
// the divisions, with the request channel paused until then, and its
// result then enters the result register. A stalled response holds the
// result register and deasserts req_tready until the result is taken.
// Reset empties the result register, loads the default sizes and steps,
// and clears all counters.
// ----------------------------------------------------------------------------
module nearest_neighbor_frame_downscaler #(
   parameter int MAX_DIM = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request: tdata = src_pixel[31:0]; tuser = frame_start[0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nnds_pkg::PIX_W-1:0]       req_tdata,
   input  logic [0:0]                       req_tuser,
   // Response: tdata = out_pixel[31:0]; tlast = row_end; tuser = frame_end[0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nnds_pkg::PIX_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   output logic [0:0]                       rsp_tuser,
   // Size registers
   input  logic                             csr_we,
   input  logic [nnds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]       csr_wdata
);

   import nnds_pkg::*;

   nnds_cmd_type    cmd;
   nnds_status_type status;

   nnds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .frame_start (req_tuser[0]),
      .status      (status),
      .cmd         (cmd)
   );

   nnds_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_pixel  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hdl/nnds_div.sv
// ----------------------------------------------------------------------------
// nnds_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient
// and remainder together with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module nnds_div #(
   parameter int DIM_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] dividend,
   input  logic [DIM_W-1:0] divisor,
   output logic             done,
   output logic [DIM_W-1:0] quot,
   output logic [DIM_W-1:0] rem
);

   localparam int CNT_W = $clog2(DIM_W + 1);

   logic [DIM_W:0]   rem_ff, rem_in;
   logic [DIM_W-1:0] quot_ff, quot_in;
   logic [DIM_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIM_W:0]   shifted;
   logic [DIM_W+1:0] trial;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      shifted = {rem_ff[DIM_W-1:0], quot_ff[DIM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DIM_W+1]) begin
            rem_in  = shifted;
            quot_in = {quot_ff[DIM_W-2:0], 1'b0};
         end else begin
            rem_in  = trial[DIM_W:0];
            quot_in = {quot_ff[DIM_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff[DIM_W-1:0];

endmodule

### hdl/nnds_datapath.sv
// ----------------------------------------------------------------------------
// nnds_datapath
// Size registers and their clamping, source and output position counters,
// incremental selection of columns and rows, the step divider and the
// registered result stage.
// ----------------------------------------------------------------------------
module nnds_datapath #(
   parameter int MAX_DIM = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nnds_pkg::nnds_cmd_type           cmd,
   output nnds_pkg::nnds_status_type        status,
   input  logic [nnds_pkg::PIX_W-1:0]       req_pixel,
   input  logic                             csr_we,
   input  logic [nnds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnds_pkg::CFG_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nnds_pkg::PIX_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   output logic [0:0]                       rsp_tuser
);

   import nnds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int CMP_W = DIM_W + 1;
   localparam int SAT_W = DIM_W + 3;
   localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);
   localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1);
   localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'(4 * MAX_DIM);

   // Size registers.
   logic [CFG_W-1:0] src_width_ff, src_height_ff, line_pitch_ff;
   logic [CFG_W-1:0] out_width_ff, out_height_ff;

   // Clamped sizes.
   logic [EXT_W-1:0] sw_x, sh_x, pitch_x, ow_x, oh_x;
   logic [DIM_W-1:0] sw_eff, sh_eff, pitch_eff, ow_eff, oh_eff;

   // Position counters and selection trackers.
   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [CNT_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [SAT_W-1:0] next_sel_col_ff, next_sel_col_in, col_rem_ff, col_rem_in;
   logic [SAT_W-1:0] next_sel_row_ff, next_sel_row_in, row_rem_ff, row_rem_in;
   logic [DIM_W-1:0] col_step_whole_ff, col_step_frac_ff;
   logic [DIM_W-1:0] row_step_whole_ff, row_step_frac_ff;

   // Held frame-start pixel and the row operands taken with it.
   logic [PIX_W-1:0] held_pix_ff;
   logic [DIM_W-1:0] snap_sh_ff, snap_oh_ff;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pix_ff;
   logic             rsp_last_ff, rsp_fend_ff;

   // Divider connections.
   logic             div_start, div_done;
   logic [DIM_W-1:0] div_dividend, div_divisor, div_quot, div_rem;

   // Step decode.
   logic             step, row_sel, sel, row_end, frame_end, line_end, last_row;
   logic [PIX_W-1:0] pix;

   function automatic logic [EXT_W-1:0] clamp_dim(input logic [EXT_W-1:0] v,
                                                  input logic [EXT_W-1:0] lo,
                                                  input logic [EXT_W-1:0] hi);
      logic [EXT_W-1:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // Moves a selection point by the whole step and carries the remainder.
   function automatic logic [2*SAT_W-1:0] advance(input logic [SAT_W-1:0] nxt,
                                                  input logic [SAT_W-1:0] rmd,
                                                  input logic [DIM_W-1:0] whole,
                                                  input logic [DIM_W-1:0] frac,
                                                  input logic [DIM_W-1:0] den);
      logic [SAT_W-1:0] n;
      logic [SAT_W-1:0] r;
      n = nxt + SAT_W'(whole);
      r = rmd + SAT_W'(frac);
      if (r >= SAT_W'(den)) begin
         r = r - SAT_W'(den);
         n = n + SAT_W'(1);
      end
      if (n > SAT_MAX) n = SAT_MAX;
      if (r > SAT_MAX) r = SAT_MAX;
      return {n, r};
   endfunction

   // Size registers take writes at any time.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         line_pitch_ff <= RST_LINE_PITCH;
         out_width_ff  <= RST_OUT_WIDTH;
         out_height_ff <= RST_OUT_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_LINE_PITCH: line_pitch_ff <= csr_wdata;
            CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata;
            CSR_OUT_HEIGHT: out_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the sizes: source to 1..MAX_DIM, pitch to at least the width,
   // output to at most the source.
   always_comb begin
      sw_x      = clamp_dim(EXT_W'(src_width_ff), ONE_EXT, MAX_EXT);
      sh_x      = clamp_dim(EXT_W'(src_height_ff), ONE_EXT, MAX_EXT);
      pitch_x   = clamp_dim(EXT_W'(line_pitch_ff), sw_x, MAX_EXT);
      ow_x      = clamp_dim(EXT_W'(out_width_ff), ONE_EXT, sw_x);
      oh_x      = clamp_dim(EXT_W'(out_height_ff), ONE_EXT, sh_x);
      sw_eff    = DIM_W'(sw_x);
      sh_eff    = DIM_W'(sh_x);
      pitch_eff = DIM_W'(pitch_x);
      ow_eff    = DIM_W'(ow_x);
      oh_eff    = DIM_W'(oh_x);
   end

   // Step divider, shared by the column and row divisions.
   assign div_start    = cmd.div_col || cmd.div_row;
   assign div_dividend = cmd.div_row ? snap_sh_ff : sw_eff;
   assign div_divisor  = cmd.div_row ? snap_oh_ff : ow_eff;

   nnds_div #(
      .DIM_W (DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Selection and position decode for the pixel being processed.
   always_comb begin
      step      = cmd.step_live || cmd.step_held;
      pix       = cmd.step_held ? held_pix_ff : req_pixel;
      row_sel   = SAT_W'(src_row_ff) == next_sel_row_ff;
      sel       = row_sel && (SAT_W'(src_col_ff) == next_sel_col_ff)
                  && (CMP_W'(src_col_ff) < CMP_W'(sw_eff));
      row_end   = (CMP_W'(out_col_ff) + CMP_W'(1)) >= CMP_W'(ow_eff);
      frame_end = row_end && ((CMP_W'(out_row_ff) + CMP_W'(1)) >= CMP_W'(oh_eff));
      line_end  = (CMP_W'(src_col_ff) + CMP_W'(1)) >= CMP_W'(pitch_eff);
      last_row  = (CMP_W'(src_row_ff) + CMP_W'(1)) >= CMP_W'(sh_eff);
   end

   // Counter updates.
   always_comb begin
      src_col_in      = src_col_ff;
      src_row_in      = src_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      next_sel_col_in = next_sel_col_ff;
      col_rem_in      = col_rem_ff;
      next_sel_row_in = next_sel_row_ff;
      row_rem_in      = row_rem_ff;
      if (cmd.capture) begin
         src_col_in      = '0;
         src_row_in      = '0;
         out_col_in      = '0;
         out_row_in      = '0;
         next_sel_col_in = '0;
         col_rem_in      = '0;
         next_sel_row_in = '0;
         row_rem_in      = '0;
      end else if (step) begin
         if (sel) begin
            out_col_in = row_end ? '0 : CNT_W'(CMP_W'(out_col_ff) + CMP_W'(1));
            {next_sel_col_in, col_rem_in} = advance(next_sel_col_ff, col_rem_ff,
                                                    col_step_whole_ff,
                                                    col_step_frac_ff, ow_eff);
         end
         if (line_end) begin
            src_col_in      = '0;
            out_col_in      = '0;
            next_sel_col_in = '0;
            col_rem_in      = '0;
            if (row_sel) begin
               if ((CMP_W'(out_row_ff) + CMP_W'(1)) >= CMP_W'(oh_eff)) begin
                  out_row_in = '0;
               end else begin
                  out_row_in = CNT_W'(CMP_W'(out_row_ff) + CMP_W'(1));
               end
               {next_sel_row_in, row_rem_in} = advance(next_sel_row_ff, row_rem_ff,
                                                       row_step_whole_ff,
                                                       row_step_frac_ff, oh_eff);
            end
            if (last_row) begin
               // End of the source frame: start over at the top.
               src_row_in      = '0;
               out_row_in      = '0;
               next_sel_row_in = '0;
               row_rem_in      = '0;
            end else begin
               src_row_in = CNT_W'(CMP_W'(src_row_ff) + CMP_W'(1));
            end
         end else begin
            src_col_in = CNT_W'(CMP_W'(src_col_ff) + CMP_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff        <= '0;
         src_row_ff        <= '0;
         out_col_ff        <= '0;
         out_row_ff        <= '0;
         next_sel_col_ff   <= '0;
         col_rem_ff        <= '0;
         next_sel_row_ff   <= '0;
         row_rem_ff        <= '0;
         col_step_whole_ff <= DIM_W'(1);
         col_step_frac_ff  <= '0;
         row_step_whole_ff <= DIM_W'(1);
         row_step_frac_ff  <= '0;
      end else begin
         src_col_ff      <= src_col_in;
         src_row_ff      <= src_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         next_sel_col_ff <= next_sel_col_in;
         col_rem_ff      <= col_rem_in;
         next_sel_row_ff <= next_sel_row_in;
         row_rem_ff      <= row_rem_in;
         if (cmd.load_col) begin
            col_step_whole_ff <= div_quot;
            col_step_frac_ff  <= div_rem;
         end
         if (cmd.load_row) begin
            row_step_whole_ff <= div_quot;
            row_step_frac_ff  <= div_rem;
         end
      end
   end

   // Held pixel and row operands for the second division.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         held_pix_ff <= req_pixel;
      end
      if (cmd.div_col) begin
         snap_sh_ff <= sh_eff;
         snap_oh_ff <= oh_eff;
      end
   end

   // Result register: loads a selected pixel, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && sel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && sel) begin
         rsp_pix_ff  <= pix;
         rsp_last_ff <= row_end;
         rsp_fend_ff <= frame_end;
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.frame_wrap = line_end && last_row;
   assign status.div_done   = div_done;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pix_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_fend_ff;

endmodule

### hdl/nnds_ctrl.sv
// ----------------------------------------------------------------------------
// nnds_ctrl
// Controller: takes pixels while streaming, holds a frame-start pixel while
// the column and row steps are divided out, and recomputes the steps when
// a source frame closes without a frame-start mark.
// ----------------------------------------------------------------------------
module nnds_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       frame_start,
   input  nnds_pkg::nnds_status_type  status,
   output nnds_pkg::nnds_cmd_type     cmd
);

   import nnds_pkg::*;

   nnds_state_type state_ff, state_in;
   logic           pend_ff, pend_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      pend_in    = pend_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               if (frame_start) begin
                  // Hold the pixel until the new steps are known.
                  cmd.capture = 1'b1;
                  cmd.div_col = 1'b1;
                  pend_in     = 1'b1;
                  state_in    = ST_DIVC;
               end else begin
                  cmd.step_live = 1'b1;
                  if (status.frame_wrap) begin
                     cmd.div_col = 1'b1;
                     pend_in     = 1'b0;
                     state_in    = ST_DIVC;
                  end
               end
            end
         end
         ST_DIVC: begin
            if (status.div_done) begin
               cmd.load_col = 1'b1;
               cmd.div_row  = 1'b1;
               state_in     = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (status.div_done) begin
               cmd.load_row = 1'b1;
               state_in     = pend_ff ? ST_PEND : ST_RUN;
            end
         end
         ST_PEND: begin
            if (status.out_free) begin
               cmd.step_held = 1'b1;
               pend_in       = 1'b0;
               // A one-pixel frame closes on its own first pixel.
               if (status.frame_wrap) begin
                  cmd.div_col = 1'b1;
                  state_in    = ST_DIVC;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

### hdl/nnds_checker.sv
// ----------------------------------------------------------------------------
// nnds_checker
// Port-level checks of the downscaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module nnds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [0:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [nnds_pkg::PIX_W-1:0]       rsp_tdata,
   input logic                             rsp_tlast,
   input logic [0:0]                       rsp_tuser
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // The end of the output frame is always the end of an output row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without row end");

   // Reset leaves the response channel empty.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A frame-start pixel pauses the request channel for the step division.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("request taken during step division");

endmodule

bind nearest_neighbor_frame_downscaler nnds_checker u_nnds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
